### rtl/r5ntt_pkg.sv
package r5ntt_pkg;

	// configuration register map
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MODULUS       = 3'd0,
		CFG_CONST_SUM     = 3'd1,
		CFG_CONST_DIFF    = 3'd2,
		CFG_CONST_ODD_A   = 3'd3,
		CFG_CONST_ODD_B   = 3'd4,
		CFG_CONST_ODD_SUM = 3'd5
	} cfg_idx_t;

	// lanes of the constant multiply and twiddle multiply groups
	localparam int NUM_CONST = 5;
	localparam int NUM_TW    = 4;

endpackage

### rtl/r5ntt_if.sv
interface r5ntt_din_if #(parameter int N = 62);
	logic         valid;
	logic         ready;
	logic         func;
	logic [N-1:0] in0;
	logic [N-1:0] in1;
	logic [N-1:0] in2;
	logic [N-1:0] in3;
	logic [N-1:0] in4;
	logic [N-1:0] twiddle1;
	logic [N-1:0] twiddle2;
	logic [N-1:0] twiddle3;
	logic [N-1:0] twiddle4;

	modport source (output valid, func, in0, in1, in2, in3, in4,
		twiddle1, twiddle2, twiddle3, twiddle4, input ready);
	modport sink (input valid, func, in0, in1, in2, in3, in4,
		twiddle1, twiddle2, twiddle3, twiddle4, output ready);
endinterface

interface r5ntt_dout_if #(parameter int N = 62);
	logic         valid;
	logic         ready;
	logic [N-1:0] out0;
	logic [N-1:0] out1;
	logic [N-1:0] out2;
	logic [N-1:0] out3;
	logic [N-1:0] out4;

	modport source (output valid, out0, out1, out2, out3, out4, input ready);
	modport sink (input valid, out0, out1, out2, out3, out4, output ready);
endinterface

interface r5ntt_cfg_if
	import r5ntt_pkg::*;
#(parameter int N = 62);
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [N-1:0]            data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/r5ntt_mulpipe.sv
// bit-serial modular multiply, one multiplier bit per stage, msb first
module r5ntt_mulpipe #(
	parameter int N      = 62,
	parameter int LANES  = 5,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [N-1:0]      m,
	input  logic              vld_i,
	input  logic [N-1:0]      a_i [LANES],
	input  logic [N-1:0]      b_i [LANES],
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [N-1:0]      p_o [LANES],
	output logic [SIDE_W-1:0] side_o
);

	logic              vld_s  [N];
	logic [N-1:0]      acc_s  [N][LANES];
	logic [N-1:0]      a_s    [N][LANES];
	logic [N-1:0]      b_s    [N][LANES];
	logic [SIDE_W-1:0] side_s [N];

	// (2r + bit*a) mod m, with r, a below m
	function automatic logic [N-1:0] dbl_add(input logic [N-1:0] r, input logic [N-1:0] a,
		input logic [N-1:0] md, input logic bit_i);
		logic [N+2:0] v;
		logic [N+2:0] d1;
		logic [N+2:0] d2;
		begin
			v  = {2'b00, r, 1'b0} + {3'b000, (bit_i ? a : {N{1'b0}})};
			d1 = v - {3'b000, md};
			d2 = v - {2'b00, md, 1'b0};
			if (!d2[N+2])
				dbl_add = d2[N-1:0];
			else if (!d1[N+2])
				dbl_add = d1[N-1:0];
			else
				dbl_add = v[N-1:0];
		end
	endfunction

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N-1:0]      acc_in [LANES];
		logic [N-1:0]      a_in   [LANES];
		logic [N-1:0]      b_in   [LANES];
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					acc_in[l] = '0;
					a_in[l]   = a_i[l];
					b_in[l]   = b_i[l];
				end
				side_in = side_i;
				vld_in  = vld_i;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					acc_in[l] = acc_s[k-1][l];
					a_in[l]   = a_s[k-1][l];
					b_in[l]   = b_s[k-1][l];
				end
				side_in = side_s[k-1];
				vld_in  = vld_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					acc_s[k][l] <= dbl_add(acc_in[l], a_in[l], m, b_in[l][N-1]);
					a_s[k][l]   <= a_in[l];
					b_s[k][l]   <= {b_in[l][N-2:0], 1'b0};
				end
				side_s[k] <= side_in;
			end
		end
	end

	assign vld_o  = vld_s[N-1];
	assign p_o    = acc_s[N-1];
	assign side_o = side_s[N-1];

endmodule

### rtl/radix5_ntt_butterfly.sv
// Winograd 5-point NTT butterfly modulo a configured modulus p, fully pipelined:
// one item per cycle unless the output stalls. Three bit-serial multiply groups of
// MOD_BITS stages each (input reduction, constant multiply, twiddle multiply) are
// joined by six short add/sub stages; the output register follows them. Outputs
// are fully reduced into 0..p-1; a modulus of zero or one gives all-zero results.
// The user must write registers through cfg (index 0 modulus, 1..5 the transform
// constants) only while the block is empty; the block itself does not enforce it.
// cfg is always ready. A stalled output holds the whole pipeline.
module radix5_ntt_butterfly
	import r5ntt_pkg::*;
#(
	parameter int MOD_BITS = 62
) (
	input  logic          clk,
	input  logic          arst_n,
	r5ntt_cfg_if.sink     cfg,
	r5ntt_din_if.sink     din,
	r5ntt_dout_if.source  dout
);

	localparam int N = MOD_BITS;

	// configuration registers
	logic [N-1:0] modulus_q;
	logic [N-1:0] const_q [NUM_CONST];

	// global advance: the whole pipeline moves unless the output is held
	logic en;
	logic dout_vld_q;

	// modular add / subtract on reduced operands
	function automatic logic [N-1:0] madd(input logic [N-1:0] a, input logic [N-1:0] b,
		input logic [N-1:0] md);
		logic [N+1:0] s;
		logic [N+1:0] d;
		begin
			s = {2'b00, a} + {2'b00, b};
			d = s - {2'b00, md};
			madd = d[N+1] ? s[N-1:0] : d[N-1:0];
		end
	endfunction

	function automatic logic [N-1:0] msub(input logic [N-1:0] a, input logic [N-1:0] b,
		input logic [N-1:0] md);
		logic [N:0] d;
		begin
			d = {1'b0, a} - {1'b0, b};
			msub = d[N] ? (d[N-1:0] + md) : d[N-1:0];
		end
	endfunction

	// config write transfer
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= N'(3);
			for (int i = 0; i < NUM_CONST; i++)
				const_q[i] <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MODULUS:       modulus_q  <= cfg.data;
				CFG_CONST_SUM:     const_q[0] <= cfg.data;
				CFG_CONST_DIFF:    const_q[1] <= cfg.data;
				CFG_CONST_ODD_A:   const_q[2] <= cfg.data;
				CFG_CONST_ODD_B:   const_q[3] <= cfg.data;
				CFG_CONST_ODD_SUM: const_q[4] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign en        = !dout_vld_q || dout.ready;
	assign din.ready = en;

	// ---------------- input reduction: x mod p = (1 * x) mod p ----------------
	localparam int RSIDE_W = 1 + NUM_TW * N;

	logic [N-1:0]       red_a [5];
	logic [N-1:0]       red_b [5];
	logic [N-1:0]       red_p [5];
	logic [RSIDE_W-1:0] red_side;
	logic               red_vld;

	always_comb begin
		for (int l = 0; l < 5; l++)
			red_a[l] = N'(1);
		// lanes hold x0, x1, x4, x2, x3 in input order
		red_b[0] = din.in0;
		red_b[1] = din.in1;
		red_b[2] = din.in2;
		red_b[3] = din.in3;
		red_b[4] = din.in4;
	end

	r5ntt_mulpipe #(.N(N), .LANES(5), .SIDE_W(RSIDE_W)) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.m      (modulus_q),
		.vld_i  (din.valid && din.ready),
		.a_i    (red_a),
		.b_i    (red_b),
		.side_i ({din.func, din.twiddle1, din.twiddle2, din.twiddle3, din.twiddle4}),
		.vld_o  (red_vld),
		.p_o    (red_p),
		.side_o (red_side)
	);

	// ---------------- pre-additions ----------------
	logic               vld_s1, vld_s2, vld_s3;
	logic [N-1:0]       x0_s1, t1_s1, t2_s1, t3_s1, t4_s1;
	logic [N-1:0]       x0_s2, s1_s2, s2_s2, s3_s2, s4_s2, s5_s2;
	logic [N-1:0]       s0_s3, s1_s3, s2_s3, s3_s3, s4_s3, s5_s3;
	logic [RSIDE_W-1:0] side_s1, side_s2, side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= red_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// x1 = lane 1, x4 = lane 2, x2 = lane 3, x3 = lane 4
			x0_s1   <= red_p[0];
			t1_s1   <= madd(red_p[1], red_p[4], modulus_q);
			t3_s1   <= msub(red_p[1], red_p[4], modulus_q);
			t2_s1   <= madd(red_p[3], red_p[2], modulus_q);
			t4_s1   <= msub(red_p[3], red_p[2], modulus_q);
			side_s1 <= red_side;

			x0_s2   <= x0_s1;
			s1_s2   <= madd(t1_s1, t2_s1, modulus_q);
			s2_s2   <= msub(t1_s1, t2_s1, modulus_q);
			s3_s2   <= t3_s1;
			s4_s2   <= t4_s1;
			s5_s2   <= madd(t3_s1, t4_s1, modulus_q);
			side_s2 <= side_s1;

			s0_s3   <= madd(x0_s2, s1_s2, modulus_q);
			s1_s3   <= s1_s2;
			s2_s3   <= s2_s2;
			s3_s3   <= s3_s2;
			s4_s3   <= s4_s2;
			s5_s3   <= s5_s2;
			side_s3 <= side_s2;
		end
	end

	// ---------------- constant multiplies ----------------
	localparam int MSIDE_W = N + RSIDE_W;

	logic [N-1:0]       cm_a [NUM_CONST];
	logic [N-1:0]       cm_p [NUM_CONST];
	logic [MSIDE_W-1:0] cm_side;
	logic               cm_vld;

	always_comb begin
		cm_a[0] = s1_s3;
		cm_a[1] = s2_s3;
		cm_a[2] = s3_s3;
		cm_a[3] = s4_s3;
		cm_a[4] = s5_s3;
	end

	// the constants need no reduction: the shift-add walk reduces as it goes
	r5ntt_mulpipe #(.N(N), .LANES(NUM_CONST), .SIDE_W(MSIDE_W)) u_cmul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.m      (modulus_q),
		.vld_i  (vld_s3),
		.a_i    (cm_a),
		.b_i    (const_q),
		.side_i ({s0_s3, side_s3}),
		.vld_o  (cm_vld),
		.p_o    (cm_p),
		.side_o (cm_side)
	);

	// ---------------- post-additions ----------------
	logic               vld_s4, vld_s5, vld_s6;
	logic [N-1:0]       s0_s4, s1_s4, p2_s4, p3_s4, p4_s4, p5_s4;
	logic [N-1:0]       s0_s5, u1_s5, u2_s5, u3_s5, u4_s5;
	logic [N-1:0]       s0_s6, f1_s6, f2_s6, f3_s6, f4_s6;
	logic [RSIDE_W-1:0] side_s4, side_s5, side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s4 <= cm_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s0_s4   <= cm_side[MSIDE_W-1 -: N];
			s1_s4   <= madd(cm_side[MSIDE_W-1 -: N], cm_p[0], modulus_q);
			p2_s4   <= cm_p[1];
			p3_s4   <= cm_p[2];
			p4_s4   <= cm_p[3];
			p5_s4   <= cm_p[4];
			side_s4 <= cm_side[RSIDE_W-1:0];

			s0_s5   <= s0_s4;
			u1_s5   <= madd(s1_s4, p2_s4, modulus_q);
			u2_s5   <= msub(s1_s4, p2_s4, modulus_q);
			u3_s5   <= madd(p3_s4, p5_s4, modulus_q);
			u4_s5   <= madd(p4_s4, p5_s4, modulus_q);
			side_s5 <= side_s4;

			s0_s6   <= s0_s5;
			f1_s6   <= madd(u1_s5, u3_s5, modulus_q);
			f2_s6   <= madd(u2_s5, u4_s5, modulus_q);
			f3_s6   <= msub(u1_s5, u3_s5, modulus_q);
			f4_s6   <= msub(u2_s5, u4_s5, modulus_q);
			side_s6 <= side_s5;
		end
	end

	// ---------------- twiddle multiplies (times one when func is clear) ----------------
	logic         tw_func;
	logic [N-1:0] tw_raw [NUM_TW];
	logic [N-1:0] tw_a   [NUM_TW];
	logic [N-1:0] tw_b   [NUM_TW];
	logic [N-1:0] tw_p   [NUM_TW];
	logic [N-1:0] tw_s0;
	logic         tw_vld;

	always_comb begin
		tw_func = side_s6[RSIDE_W-1];
		for (int l = 0; l < NUM_TW; l++)
			tw_raw[l] = side_s6[(NUM_TW-l)*N-1 -: N];
		// lanes feed out1..out4
		tw_a[0] = f4_s6;
		tw_a[1] = f3_s6;
		tw_a[2] = f1_s6;
		tw_a[3] = f2_s6;
		for (int l = 0; l < NUM_TW; l++)
			tw_b[l] = tw_func ? tw_raw[l] : N'(1);
	end

	r5ntt_mulpipe #(.N(N), .LANES(NUM_TW), .SIDE_W(N)) u_twmul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.m      (modulus_q),
		.vld_i  (vld_s6),
		.a_i    (tw_a),
		.b_i    (tw_b),
		.side_i (s0_s6),
		.vld_o  (tw_vld),
		.p_o    (tw_p),
		.side_o (tw_s0)
	);

	// ---------------- output register ----------------
	logic         zero_out;
	logic [N-1:0] out_q [5];

	// a modulus below two forces all results to zero
	assign zero_out = (modulus_q < N'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dout_vld_q <= 1'b0;
		else if (en)
			dout_vld_q <= tw_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q[0] <= zero_out ? '0 : tw_s0;
			for (int l = 0; l < NUM_TW; l++)
				out_q[l+1] <= zero_out ? '0 : tw_p[l];
		end
	end

	assign dout.valid = dout_vld_q;
	assign dout.out0  = out_q[0];
	assign dout.out1  = out_q[1];
	assign dout.out2  = out_q[2];
	assign dout.out3  = out_q[3];
	assign dout.out4  = out_q[4];

	// ---------------- checks ----------------
	// a held result must block new input transfers
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.ready) |-> !din.ready)
		else $error("input taken while output is held");

	// a result only appears when the last multiply stage held a valid item
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dout_vld_q) |-> $past(tw_vld))
		else $error("output valid without pipeline item");

endmodule

### verif/testbench.sv
module testbench;
	import r5ntt_pkg::*;

	localparam int          MOD_BITS   = 62;
	localparam int          LATENCY    = 3 * MOD_BITS + 7;
	localparam int          DRAIN      = LATENCY + 20;
	localparam int          CYCLE_CAP  = 400000;
	localparam int          RAND_ITEMS = 110;
	localparam logic [61:0] MAX62      = {62{1'b1}};

	// field types at the block's widths
	typedef logic [MOD_BITS-1:0] resid_t;

	typedef struct {
		logic   func;
		resid_t x[5];
		resid_t tw[4];
	} bfly_in_t;

	typedef struct {
		resid_t o[5];
	} bfly_out_t;

	// directed stimulus row; known marks a result typed in by hand
	typedef struct {
		bfly_in_t  stim;
		bit        known;
		bfly_out_t want;
	} vec_row_t;

	// idling modes
	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;

	r5ntt_cfg_if  #(.N(MOD_BITS)) cfg();
	r5ntt_din_if  #(.N(MOD_BITS)) din();
	r5ntt_dout_if #(.N(MOD_BITS)) dout();

	radix5_ntt_butterfly #(
		.MOD_BITS(MOD_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.din    (din),
		.dout   (dout)
	);

	// shadow copy of the configuration registers
	resid_t     cur_mod;
	resid_t     cur_const[5];

	bfly_out_t  pending_outs[$];
	int         fail_count;
	int         cycles;
	idle_mode_t mode;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------------------------------------------------------------
	// modular helpers, operands below the modulus
	// ---------------------------------------------------------------------
	function automatic resid_t add_mod(resid_t a, resid_t b);
		logic [63:0] s;
		s = 64'(a) + 64'(b);
		return (s >= 64'(cur_mod)) ? resid_t'(s - 64'(cur_mod)) : resid_t'(s);
	endfunction

	function automatic resid_t sub_mod(resid_t a, resid_t b);
		return (a >= b) ? a - b : resid_t'(64'(a) + 64'(cur_mod) - 64'(b));
	endfunction

	function automatic resid_t mul_mod(resid_t a, resid_t b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return resid_t'(p % 128'(cur_mod));
	endfunction

	// winograd 5-point butterfly in the block's permuted order
	function automatic bfly_out_t butterfly(bfly_in_t it);
		bfly_out_t r;
		resid_t    x0, x1, x2, x3, x4;
		resid_t    t1, t2, t3, t4, s0, s1, s2, s3, s4, s5, f1, f2, f3, f4;
		resid_t    c[5];
		if (cur_mod < resid_t'(2)) begin
			// degenerate modulus gives all zeros
			foreach (r.o[i]) r.o[i] = '0;
			return r;
		end
		foreach (c[i]) c[i] = cur_const[i] % cur_mod;
		// input positions 2..4 carry x4, x2, x3
		x0 = it.x[0] % cur_mod;
		x1 = it.x[1] % cur_mod;
		x4 = it.x[2] % cur_mod;
		x2 = it.x[3] % cur_mod;
		x3 = it.x[4] % cur_mod;
		t1 = add_mod(x1, x3);
		t3 = sub_mod(x1, x3);
		t2 = add_mod(x2, x4);
		t4 = sub_mod(x2, x4);
		s1 = add_mod(t1, t2);
		s2 = sub_mod(t1, t2);
		s3 = t3;
		s4 = t4;
		s5 = add_mod(t3, t4);
		s0 = add_mod(x0, s1);
		s1 = mul_mod(s1, c[0]);
		s2 = mul_mod(s2, c[1]);
		s3 = mul_mod(s3, c[2]);
		s4 = mul_mod(s4, c[3]);
		s5 = mul_mod(s5, c[4]);
		s1 = add_mod(s0, s1);
		t1 = add_mod(s1, s2);
		t2 = sub_mod(s1, s2);
		t3 = add_mod(s3, s5);
		t4 = add_mod(s4, s5);
		f1 = add_mod(t1, t3);
		f2 = add_mod(t2, t4);
		f3 = sub_mod(t1, t3);
		f4 = sub_mod(t2, t4);
		if (it.func) begin
			f4 = mul_mod(f4, it.tw[0] % cur_mod);
			f3 = mul_mod(f3, it.tw[1] % cur_mod);
			f1 = mul_mod(f1, it.tw[2] % cur_mod);
			f2 = mul_mod(f2, it.tw[3] % cur_mod);
		end
		r.o[0] = s0;
		r.o[1] = f4;
		r.o[2] = f3;
		r.o[3] = f1;
		r.o[4] = f2;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// random values, biased toward the edges of the current modulus
	// ---------------------------------------------------------------------
	function automatic resid_t rand_wide();
		return resid_t'({$urandom, $urandom});
	endfunction

	function automatic resid_t rand_resid();
		resid_t v;
		v = rand_wide();
		case ($urandom_range(0, 9))
			0: begin
				v = '0;
			end
			1: begin
				v = MAX62;
			end
			2: begin
				v = (cur_mod > 0) ? cur_mod - resid_t'(1) : '0;
			end
			3: begin
				v = cur_mod;
			end
			4: begin
				v = cur_mod + resid_t'($urandom_range(1, 50));
			end
			5: begin
				v = (cur_mod > 0) ? v % cur_mod : v;
			end
			default: ;
		endcase
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// configuration writes; valid stays high across back-to-back writes
	// ---------------------------------------------------------------------
	task automatic reg_write(logic [CFG_IDX_BITS-1:0] idx, resid_t val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_MODULUS:       cur_mod      = val;
			CFG_CONST_SUM:     cur_const[0] = val;
			CFG_CONST_DIFF:    cur_const[1] = val;
			CFG_CONST_ODD_A:   cur_const[2] = val;
			CFG_CONST_ODD_B:   cur_const[3] = val;
			CFG_CONST_ODD_SUM: cur_const[4] = val;
			default: ;  // unmapped index, ignored by the block
		endcase
	endtask

	task automatic load_config(resid_t m, int cmode);
		resid_t c;
		reg_write(CFG_MODULUS, m);
		for (int i = 0; i < NUM_CONST; i++) begin
			case (cmode)
				0: c = '0;
				1: c = MAX62;
				default: c = rand_resid();
			endcase
			reg_write(cfg_idx_t'(CFG_CONST_SUM + i), c);
		end
		// unmapped indexes must not disturb anything
		reg_write(CFG_IDX_BITS'(CFG_CONST_ODD_SUM + 1), rand_wide());
		reg_write(CFG_IDX_BITS'(CFG_CONST_ODD_SUM + 2), rand_wide());
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// input transfer; the expectation is queued at the accepting edge
	// ---------------------------------------------------------------------
	task automatic send_item(bfly_in_t it);
		while ((mode == IDLE_SEND && $urandom_range(0, 99) < 45) ||
		       (mode == IDLE_BOTH && $urandom_range(0, 99) < 28)) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid    <= 1'b1;
		din.func     <= it.func;
		din.in0      <= it.x[0];
		din.in1      <= it.x[1];
		din.in2      <= it.x[2];
		din.in3      <= it.x[3];
		din.in4      <= it.x[4];
		din.twiddle1 <= it.tw[0];
		din.twiddle2 <= it.tw[1];
		din.twiddle3 <= it.tw[2];
		din.twiddle4 <= it.tw[3];
		do @(posedge clk); while (!din.ready);
		pending_outs.push_back(butterfly(it));
	endtask

	// wait for the pipeline to drain before touching configuration
	task automatic drain_pipe();
		din.valid <= 1'b0;
		while (pending_outs.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// output side: random stalls, compare each transfer with the oldest
	// expectation, cycle cap
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		bfly_out_t w;
		resid_t    got[5];
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_outs.size());
			$display("Some tests failed");
			$finish;
		end
		if (dout.valid && dout.ready) begin
			got = '{dout.out0, dout.out1, dout.out2, dout.out3, dout.out4};
			if (pending_outs.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %h %h", $time,
					got[0], got[1], got[2], got[3], got[4]);
				fail_count++;
			end else begin
				w = pending_outs.pop_front();
				for (int i = 0; i < 5; i++) begin
					if (got[i] !== w.o[i]) begin
						$display("%0t: out%0d expected %h actual %h", $time, i,
							w.o[i], got[i]);
						fail_count++;
					end
				end
			end
		end
		case (mode)
			IDLE_RECV: dout.ready <= ($urandom_range(0, 99) >= 45);
			IDLE_BOTH: dout.ready <= ($urandom_range(0, 99) >= 28);
			default:   dout.ready <= 1'b1;
		endcase
	end

	// ---------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------
	initial begin
		vec_row_t  rows[$];
		vec_row_t  row;
		bfly_in_t  it;
		resid_t    moduli[9];
		int        phase;

		fail_count = 0;
		cycles     = 0;
		mode       = IDLE_NONE;
		arst_n     = 1'b0;
		cfg.valid  = 1'b0;
		cfg.index  = '0;
		cfg.data   = '0;
		din.valid  = 1'b0;
		din.func   = 1'b0;
		din.in0    = '0;
		din.in1    = '0;
		din.in2    = '0;
		din.in3    = '0;
		din.in4    = '0;
		din.twiddle1 = '0;
		din.twiddle2 = '0;
		din.twiddle3 = '0;
		din.twiddle4 = '0;
		dout.ready = 1'b1;

		// reset values of the registers
		cur_mod = resid_t'(3);
		foreach (cur_const[i]) cur_const[i] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset configuration (p = 3, all constants zero):
		// with zero constants and func clear every output is the sum mod 3
		row.known = 1'b1;
		row.stim.func = 1'b0;
		foreach (row.stim.x[i]) row.stim.x[i] = '0;
		foreach (row.stim.tw[i]) row.stim.tw[i] = '0;
		row.want.o = '{default: '0};
		rows.push_back(row);                      // all zero
		row.stim.x[0] = resid_t'(1);
		row.want.o = '{default: 62'd1};
		rows.push_back(row);                      // unit in x0
		row.stim.x = '{default: MAX62};
		row.want.o = '{default: '0};
		rows.push_back(row);                      // all fields at maximum
		row.stim.x = '{62'd2, 62'd2, 62'd0, 62'd0, 62'd0};
		row.want.o = '{default: 62'd1};
		rows.push_back(row);                      // sum wraps past p
		row.stim.func = 1'b1;
		row.stim.x = '{62'd1, 62'd0, 62'd0, 62'd0, 62'd0};
		row.stim.tw = '{default: MAX62};
		row.want.o = '{62'd1, 62'd0, 62'd0, 62'd0, 62'd0};
		rows.push_back(row);                      // twiddles reduce to zero
		row.stim.tw = '{default: 62'd1};
		row.want.o = '{default: 62'd1};
		rows.push_back(row);                      // unit twiddles
		// inputs equal to p and just above it, checked by the predictor
		row.known = 1'b0;
		row.stim.func = 1'b0;
		row.stim.x = '{62'd3, 62'd4, 62'd5, 62'd6, 62'd7};
		rows.push_back(row);
		row.stim.func = 1'b1;
		row.stim.tw = '{62'd2, 62'd3, 62'd4, 62'd5};
		rows.push_back(row);
		row.stim.x = '{default: 62'h2aaa_aaaa_aaaa_aaaa};
		row.stim.tw = '{default: 62'h1555_5555_5555_5555};
		rows.push_back(row);

		foreach (rows[r]) begin
			send_item(rows[r].stim);
			// hand-typed results override the predictor
			if (rows[r].known) begin
				void'(pending_outs.pop_back());
				pending_outs.push_back(rows[r].want);
			end
		end
		drain_pipe();

		// large prime, zero, one, composite, even, small primes, random odd
		moduli = '{62'd4611686018427387847, 62'd0, 62'd1, MAX62,
			MAX62 - 1, 62'd257, 62'd65537, 62'd3, 62'd0};
		moduli[8] = rand_wide() | 62'd1;

		for (phase = 0; phase < 9; phase++) begin
			load_config(moduli[phase], phase % 3);
			mode = idle_mode_t'(phase % 4);
			for (int n = 0; n < RAND_ITEMS; n++) begin
				it.func = 1'($urandom_range(0, 1));
				foreach (it.x[i]) it.x[i] = rand_resid();
				foreach (it.tw[i]) it.tw[i] = rand_resid();
				send_item(it);
			end
			drain_pipe();
		end

		mode = IDLE_NONE;
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/r5ntt_pkg.sv
rtl/r5ntt_if.sv
rtl/r5ntt_mulpipe.sv
rtl/radix5_ntt_butterfly.sv
verif/testbench.sv
